// ----- design/bsbp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsbp_pkg
// Shared types, constants and helper functions of the box screen bounds
// projector.
// ----------------------------------------------------------------------------
package bsbp_pkg;

    localparam int COORD_W         = 24;
    localparam int ENTRY_W         = 32;
    localparam int PROD_W          = COORD_W + ENTRY_W;
    localparam int ACC_W           = PROD_W + 4;
    localparam int MAG_W           = ACC_W;
    localparam int Q_W             = 32;
    localparam int FRAC_W          = 16;
    localparam int NUM_W           = MAG_W + Q_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = Q_W / STEPS_PER_STAGE;
    localparam int N_CORNERS       = 8;
    localparam int N_COLS          = 4;
    localparam int N_AXES          = 3;
    localparam int N_QUOT          = N_CORNERS * N_AXES;
    localparam int CFG_REGS        = 8;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int TRANS_SHIFT     = 8;

    localparam int COL_X = 0;
    localparam int COL_Y = 1;
    localparam int COL_Z = 2;
    localparam int COL_W = 3;

    localparam logic signed [ACC_W-1:0] NEAR_EPS = ACC_W'(168);
    localparam logic signed [33:0]      Q16_ONE  = 34'sd65536;
    localparam logic signed [Q_W-1:0]   S32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0]   S32_MIN  = 32'sh8000_0000;

    typedef logic signed [COORD_W-1:0]            coord_t;
    typedef logic signed [ENTRY_W-1:0]            entry_t;
    typedef logic signed [ACC_W-1:0]              acc_t;
    typedef logic signed [Q_W-1:0]                q16_t;
    typedef logic [CFG_REGS-1:0][CFG_DATA_W-1:0]  cfg_array_t;

    localparam cfg_array_t CFG_RESET = {
        64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
    };

    typedef enum logic [1:0] {
        QM_NORMAL = 2'd0,
        QM_MAX    = 2'd1,
        QM_MIN    = 2'd2,
        QM_ZERO   = 2'd3
    } qmode_t;

    typedef struct packed {
        logic                    near;
        qmode_t [N_QUOT-1:0]     mode;
        logic   [N_QUOT-1:0]     neg;
    } side_t;

    typedef struct packed {
        logic vis;
        q16_t mnx;
        q16_t mny;
        q16_t mxx;
        q16_t mxy;
        q16_t mnz;
    } result_t;

    function automatic entry_t cfg_entry(input cfg_array_t cfg, input int r, input int c);
        logic [CFG_DATA_W-1:0] word;
        word = cfg[(r << 1) + (c >> 1)];
        return ((c & 1) != 0) ? entry_t'(word[63:32]) : entry_t'(word[31:0]);
    endfunction

    function automatic q16_t sat32(input logic signed [33:0] v);
        if (v > 34'(S32_MAX))
            return S32_MAX;
        if (v < 34'(S32_MIN))
            return S32_MIN;
        return q16_t'(v);
    endfunction

    function automatic q16_t fin_quot(input qmode_t m, input logic neg,
                                      input logic [Q_W-1:0] mag);
        q16_t r;
        case (m)
            QM_MAX:  r = S32_MAX;
            QM_MIN:  r = S32_MIN;
            QM_ZERO: r = '0;
            default:
            begin
                if (neg)
                    r = (mag > 32'h8000_0000) ? S32_MIN : q16_t'(-mag);
                else
                    r = mag[Q_W-1] ? S32_MAX : q16_t'(mag);
            end
        endcase
        return r;
    endfunction

    function automatic q16_t smin(input q16_t a, input q16_t b);
        return (b < a) ? b : a;
    endfunction

    function automatic q16_t smax(input q16_t a, input q16_t b);
        return (b > a) ? b : a;
    endfunction

endpackage

// ----- design/bsbp_box_if.sv -----
// ----------------------------------------------------------------------------
// bsbp_box_if
// Input channel carrying one axis-aligned box per beat.
// ----------------------------------------------------------------------------
interface bsbp_box_if import bsbp_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;

    modport source (output valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, input ready);
    modport sink (input valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, output ready);
endinterface

// ----- design/bsbp_bounds_if.sv -----
// ----------------------------------------------------------------------------
// bsbp_bounds_if
// Output channel carrying the screen rectangle and nearest depth per beat.
// ----------------------------------------------------------------------------
interface bsbp_bounds_if import bsbp_pkg::*; ();
    logic valid;
    logic ready;
    logic assume_visible;
    q16_t rect_min_x;
    q16_t rect_min_y;
    q16_t rect_max_x;
    q16_t rect_max_y;
    q16_t nearest_depth;

    modport source (output valid, assume_visible, rect_min_x, rect_min_y,
                    rect_max_x, rect_max_y, nearest_depth, input ready);
    modport sink (input valid, assume_visible, rect_min_x, rect_min_y,
                  rect_max_x, rect_max_y, nearest_depth, output ready);
endinterface

// ----- design/bsbp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bsbp_cfg_if
// Register write channel: one register index and its data per beat.
// ----------------------------------------------------------------------------
interface bsbp_cfg_if import bsbp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/bsbp_transform.sv -----
// ----------------------------------------------------------------------------
// bsbp_transform
// Two-stage corner transform: matrix products per axis value, then the
// column sums x', y', z', w' of all eight corners.
// ----------------------------------------------------------------------------
module bsbp_transform import bsbp_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] adv,
    input  cfg_array_t cfg,
    input  coord_t     lo [N_AXES],
    input  coord_t     hi [N_AXES],
    output acc_t       col [N_CORNERS][N_COLS]
);

    logic signed [PROD_W-1:0] prod_reg [N_AXES][2][N_COLS];
    acc_t                     col_reg  [N_CORNERS][N_COLS];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int r = 0; r < N_AXES; r++)
            begin
                for (int c = 0; c < N_COLS; c++)
                begin
                    prod_reg[r][0][c] <= PROD_W'(lo[r]) * PROD_W'(cfg_entry(cfg, r, c));
                    prod_reg[r][1][c] <= PROD_W'(hi[r]) * PROD_W'(cfg_entry(cfg, r, c));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < N_CORNERS; k++)
            begin
                for (int c = 0; c < N_COLS; c++)
                begin
                    col_reg[k][c] <= ACC_W'(prod_reg[0][k & 1][c])
                                   + ACC_W'(prod_reg[1][(k >> 1) & 1][c])
                                   + ACC_W'(prod_reg[2][(k >> 2) & 1][c])
                                   + (ACC_W'(cfg_entry(cfg, N_AXES, c)) <<< TRANS_SHIFT);
                end
            end
        end
    end

    assign col = col_reg;

endmodule

// ----- design/bsbp_divider.sv -----
// ----------------------------------------------------------------------------
// bsbp_divider
// Pipelined restoring divider: floor(num * 2^16 / den) for quotients that
// fit in 32 bits, two quotient bits per stage.
// ----------------------------------------------------------------------------
module bsbp_divider import bsbp_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] adv,
    input  logic [MAG_W-1:0]      num,
    input  logic [MAG_W-1:0]      den,
    output logic [Q_W-1:0]        quo
);

    logic [NUM_W-1:0] n_reg [DIV_STAGES];
    logic [MAG_W-1:0] d_reg [DIV_STAGES];
    logic [Q_W-1:0]   q_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic [NUM_W-1:0] n_in;
            logic [NUM_W-1:0] n_next;
            logic [MAG_W-1:0] d_in;
            logic [Q_W-1:0]   q_in;
            logic [Q_W-1:0]   q_next;

            if (s == 0)
            begin : g_first
                assign n_in = NUM_W'({num, {FRAC_W{1'b0}}});
                assign d_in = den;
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign n_in = n_reg[s-1];
                assign d_in = d_reg[s-1];
                assign q_in = q_reg[s-1];
            end

            always_comb
            begin
                logic [NUM_W-1:0] n;
                logic [NUM_W-1:0] trial;
                logic [Q_W-1:0]   q;
                n = n_in;
                q = q_in;
                for (int j = 0; j < STEPS_PER_STAGE; j++)
                begin
                    trial = NUM_W'(d_in) << (Q_W - 1 - STEPS_PER_STAGE * s - j);
                    if (n >= trial)
                    begin
                        n = n - trial;
                        q[Q_W - 1 - STEPS_PER_STAGE * s - j] = 1'b1;
                    end
                end
                n_next = n;
                q_next = q;
            end

            always_ff @(posedge clk)
            begin
                if (adv[s])
                begin
                    n_reg[s] <= n_next;
                    d_reg[s] <= d_in;
                    q_reg[s] <= q_next;
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_STAGES-1];

endmodule

// ----- design/bsbp_reduce.sv -----
// ----------------------------------------------------------------------------
// bsbp_reduce
// Two-stage min/max tree over the eight projected corners, with the
// assumed-visible override in the output register.
// ----------------------------------------------------------------------------
module bsbp_reduce import bsbp_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] adv,
    input  q16_t       sx [N_CORNERS],
    input  q16_t       sy [N_CORNERS],
    input  q16_t       dz [N_CORNERS],
    input  logic       near,
    output result_t    res
);

    localparam int GROUPS = 2;
    localparam int GSIZE  = N_CORNERS / GROUPS;

    q16_t    mnx_reg [GROUPS];
    q16_t    mny_reg [GROUPS];
    q16_t    mxx_reg [GROUPS];
    q16_t    mxy_reg [GROUPS];
    q16_t    mnz_reg [GROUPS];
    logic    near_reg;
    result_t res_reg;
    result_t res_next;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            near_reg <= near;
            for (int g = 0; g < GROUPS; g++)
            begin
                mnx_reg[g] <= smin(smin(sx[g*GSIZE], sx[g*GSIZE+1]),
                                   smin(sx[g*GSIZE+2], sx[g*GSIZE+3]));
                mxx_reg[g] <= smax(smax(sx[g*GSIZE], sx[g*GSIZE+1]),
                                   smax(sx[g*GSIZE+2], sx[g*GSIZE+3]));
                mny_reg[g] <= smin(smin(sy[g*GSIZE], sy[g*GSIZE+1]),
                                   smin(sy[g*GSIZE+2], sy[g*GSIZE+3]));
                mxy_reg[g] <= smax(smax(sy[g*GSIZE], sy[g*GSIZE+1]),
                                   smax(sy[g*GSIZE+2], sy[g*GSIZE+3]));
                mnz_reg[g] <= smin(smin(dz[g*GSIZE], dz[g*GSIZE+1]),
                                   smin(dz[g*GSIZE+2], dz[g*GSIZE+3]));
            end
        end
    end

    always_comb
    begin
        res_next.vis = near_reg;
        res_next.mnx = smin(mnx_reg[0], mnx_reg[1]);
        res_next.mxx = smax(mxx_reg[0], mxx_reg[1]);
        res_next.mny = smin(mny_reg[0], mny_reg[1]);
        res_next.mxy = smax(mxy_reg[0], mxy_reg[1]);
        res_next.mnz = smin(mnz_reg[0], mnz_reg[1]);
        if (near_reg)
        begin
            res_next.mnx = '0;
            res_next.mxx = '0;
            res_next.mny = '0;
            res_next.mxy = '0;
            res_next.mnz = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- design/box_screen_bounds_projector_core.sv -----
// ----------------------------------------------------------------------------
// box_screen_bounds_projector_core
// Projects the eight corners of a box through the view-projection matrix
// and returns the screen rectangle and nearest depth.
// ----------------------------------------------------------------------------
// The block takes one box per cycle unless the pipeline is full and the
// output is stalled. Each beat passes through the matrix product and column
// sum registers, the sign and range check register, the pipelined dividers
// (two quotient bits per divider stage for each of the 24 quotients), the
// final saturation register and the min/max tree registers. Every stage holds its beat under
// backpressure, and empty stages fill up while the output waits, so input
// beats keep being taken until the pipeline is full. Matrix rows are written
// through the register channel, which is always ready; write them only while
// no box is in flight.
module box_screen_bounds_projector_core import bsbp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bsbp_box_if.sink      box,
    bsbp_bounds_if.source bounds,
    bsbp_cfg_if.sink      cfg
);

    localparam int ST_PROD  = 0;
    localparam int ST_COL   = 1;
    localparam int ST_PREP  = 2;
    localparam int ST_DIV   = 3;
    localparam int ST_FIN   = ST_DIV + DIV_STAGES;
    localparam int ST_RED   = ST_FIN + 1;
    localparam int NSTAGE   = ST_RED + 2;

    cfg_array_t          cfg_reg;
    cfg_array_t          cfg_next;
    logic [NSTAGE-1:0]   v_reg;
    logic [NSTAGE-1:0]   v_next;
    logic [NSTAGE-1:0]   adv;

    coord_t              lo [N_AXES];
    coord_t              hi [N_AXES];
    acc_t                col [N_CORNERS][N_COLS];

    logic [MAG_W-1:0]    an_reg [N_QUOT];
    logic [MAG_W-1:0]    ad_reg [N_QUOT];
    logic [MAG_W-1:0]    an_next [N_QUOT];
    logic [MAG_W-1:0]    ad_next [N_QUOT];
    side_t               prep_reg;
    side_t               prep_next;
    side_t               side_reg [DIV_STAGES];
    logic [Q_W-1:0]      quo [N_QUOT];

    q16_t                sx_reg [N_CORNERS];
    q16_t                sy_reg [N_CORNERS];
    q16_t                dz_reg [N_CORNERS];
    logic                near_reg;
    result_t             res;

    // Register channel.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && (cfg.index < CFG_IDX_W'(CFG_REGS)))
            cfg_next[cfg.index[$clog2(CFG_REGS)-1:0]] = cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    // Pipeline control: a stage loads when it is empty or its beat moves on.
    always_comb
    begin
        adv[NSTAGE-1] = !v_reg[NSTAGE-1] || bounds.ready;
        for (int s = NSTAGE - 2; s >= 0; s--)
            adv[s] = !v_reg[s] || adv[s+1];
        v_next[0] = adv[0] ? box.valid : v_reg[0];
        for (int s = 1; s < NSTAGE; s++)
            v_next[s] = adv[s] ? v_reg[s-1] : v_reg[s];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign box.ready = adv[0];

    // Corner transform.
    assign lo[0] = box.box_min_x;
    assign lo[1] = box.box_min_y;
    assign lo[2] = box.box_min_z;
    assign hi[0] = box.box_max_x;
    assign hi[1] = box.box_max_y;
    assign hi[2] = box.box_max_z;

    bsbp_transform u_transform (
        .clk (clk),
        .adv (adv[ST_COL:ST_PROD]),
        .cfg (cfg_reg),
        .lo  (lo),
        .hi  (hi),
        .col (col)
    );

    // Sign, range and near checks ahead of the dividers.
    always_comb
    begin
        acc_t             num;
        acc_t             den;
        logic [MAG_W-1:0] an;
        logic [MAG_W-1:0] ad;
        prep_next.near = 1'b0;
        for (int k = 0; k < N_CORNERS; k++)
        begin
            den = col[k][COL_W];
            ad  = den[ACC_W-1] ? MAG_W'(-den) : MAG_W'(den);
            if (col[k][COL_Z] < NEAR_EPS)
                prep_next.near = 1'b1;
            for (int j = 0; j < N_AXES; j++)
            begin
                num = col[k][j];
                an  = num[ACC_W-1] ? MAG_W'(-num) : MAG_W'(num);
                an_next[k*N_AXES+j]       = an;
                ad_next[k*N_AXES+j]       = ad;
                prep_next.neg[k*N_AXES+j] = num[ACC_W-1] ^ den[ACC_W-1];
                if (den == '0)
                begin
                    if (num[ACC_W-1])
                        prep_next.mode[k*N_AXES+j] = QM_MIN;
                    else if (num == '0)
                        prep_next.mode[k*N_AXES+j] = QM_ZERO;
                    else
                        prep_next.mode[k*N_AXES+j] = QM_MAX;
                end
                else if ((MAG_W+FRAC_W)'(an) >= {ad, {FRAC_W{1'b0}}})
                    prep_next.mode[k*N_AXES+j] =
                        (num[ACC_W-1] ^ den[ACC_W-1]) ? QM_MIN : QM_MAX;
                else
                    prep_next.mode[k*N_AXES+j] = QM_NORMAL;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_PREP])
        begin
            an_reg   <= an_next;
            ad_reg   <= ad_next;
            prep_reg <= prep_next;
        end
    end

    // Dividers and the matching side information.
    genvar q;
    generate
        for (q = 0; q < N_QUOT; q++)
        begin : g_div
            bsbp_divider u_divider (
                .clk (clk),
                .adv (adv[ST_DIV+DIV_STAGES-1:ST_DIV]),
                .num (an_reg[q]),
                .den (ad_reg[q]),
                .quo (quo[q])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (adv[ST_DIV+s])
                side_reg[s] <= (s == 0) ? prep_reg : side_reg[(s == 0) ? 0 : s - 1];
        end
    end

    // Quotient saturation and screen mapping.
    always_ff @(posedge clk)
    begin
        if (adv[ST_FIN])
        begin
            near_reg <= side_reg[DIV_STAGES-1].near;
            for (int k = 0; k < N_CORNERS; k++)
            begin
                sx_reg[k] <= sat32(Q16_ONE + 34'(fin_quot(
                    side_reg[DIV_STAGES-1].mode[k*N_AXES+COL_X],
                    side_reg[DIV_STAGES-1].neg[k*N_AXES+COL_X],
                    quo[k*N_AXES+COL_X])));
                sy_reg[k] <= sat32(Q16_ONE - 34'(fin_quot(
                    side_reg[DIV_STAGES-1].mode[k*N_AXES+COL_Y],
                    side_reg[DIV_STAGES-1].neg[k*N_AXES+COL_Y],
                    quo[k*N_AXES+COL_Y])));
                dz_reg[k] <= fin_quot(
                    side_reg[DIV_STAGES-1].mode[k*N_AXES+COL_Z],
                    side_reg[DIV_STAGES-1].neg[k*N_AXES+COL_Z],
                    quo[k*N_AXES+COL_Z]);
            end
        end
    end

    bsbp_reduce u_reduce (
        .clk  (clk),
        .adv  (adv[NSTAGE-1:ST_RED]),
        .sx   (sx_reg),
        .sy   (sy_reg),
        .dz   (dz_reg),
        .near (near_reg),
        .res  (res)
    );

    assign bounds.valid          = v_reg[NSTAGE-1];
    assign bounds.assume_visible = res.vis;
    assign bounds.rect_min_x     = res.mnx;
    assign bounds.rect_min_y     = res.mny;
    assign bounds.rect_max_x     = res.mxx;
    assign bounds.rect_max_y     = res.mxy;
    assign bounds.nearest_depth  = res.mnz;

`ifndef SYNTHESIS
    a_visible_zero: assert property (@(posedge clk) disable iff (!rst_n)
        bounds.valid && bounds.assume_visible |->
            bounds.rect_min_x == 0 && bounds.rect_max_x == 0 &&
            bounds.rect_min_y == 0 && bounds.rect_max_y == 0 &&
            bounds.nearest_depth == 0)
        else $error("assumed-visible beat carries a nonzero rectangle");

    a_rect_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        bounds.valid && !bounds.assume_visible |->
            bounds.rect_min_x <= bounds.rect_max_x &&
            bounds.rect_min_y <= bounds.rect_max_y)
        else $error("rectangle minimum exceeds maximum");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !box.ready |-> (&v_reg) && !bounds.ready)
        else $error("input stalled while the pipeline has room");
`endif

endmodule
